// File: src/atrlc_pkg.sv
package atrlc_pkg;

    // line buffer sizing
    localparam int LINE_MAX     = 128;
    localparam int LEN_CAP      = ((LINE_MAX - 1) < 127) ? (LINE_MAX - 1) : 127;
    localparam int LEN_W        = 7;
    localparam int PREFIX_DEPTH = 9;
    localparam int PREFIX_IDX_W = $clog2(PREFIX_DEPTH);

    // field widths
    localparam int BYTE_W     = 8;
    localparam int FUNC_W     = 2;
    localparam int MODE_W     = 2;
    localparam int TICK_W     = 16;
    localparam int REG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int Q_PTR_W     = $clog2(QUEUE_DEPTH);
    localparam int Q_CNT_W     = $clog2(QUEUE_DEPTH + 1);

    // register indexes
    localparam logic [REG_IDX_W-1:0] REG_WAIT_MODE = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_TIMEOUT   = 2'd1;

    localparam logic [TICK_W-1:0] TIMEOUT_RESET = 16'd1000;
    localparam logic [TICK_W-1:0] TICK_MAX      = '1;

    // special characters
    localparam logic [BYTE_W-1:0] CH_CR     = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_LF     = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_PROMPT = 8'h3E;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_BYTE  = 2'd0,
        FUNC_TICK  = 2'd1,
        FUNC_START = 2'd2,
        FUNC_NONE  = 2'd3
    } t_func;

    typedef enum logic [MODE_W-1:0] {
        MODE_COLLECT = 2'd0,
        MODE_READY   = 2'd1,
        MODE_SEND    = 2'd2
    } t_mode;

    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_LINES  = 2'd1,
        PH_PROMPT = 2'd2
    } t_phase;

    typedef enum logic [1:0] {
        EV_LINE    = 2'd0,
        EV_PROMPT  = 2'd1,
        EV_TIMEOUT = 2'd2
    } t_event;

    typedef enum logic [3:0] {
        CL_BLANK     = 4'd0,
        CL_OK        = 4'd1,
        CL_ERROR     = 4'd2,
        CL_FAIL      = 4'd3,
        CL_BUSY      = 4'd4,
        CL_READY     = 4'd5,
        CL_SEND_OK   = 4'd6,
        CL_SEND_FAIL = 4'd7,
        CL_OTHER     = 4'd8
    } t_class;

    typedef enum logic [1:0] {
        ST_WAIT    = 2'd0,
        ST_SUCCESS = 2'd1,
        ST_ERROR   = 2'd2,
        ST_TIMEOUT = 2'd3
    } t_status;

    // one queued result
    typedef struct packed {
        t_event             event_kind;
        t_class             line_class;
        logic [LEN_W-1:0]   line_length;
        t_status            wait_status;
    } t_result;

    // queue status seen by both sides
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

// File: src/atrlc_if.sv
interface atrlc_in_if;
    import atrlc_pkg::*;

    logic              valid;
    logic              ready;
    logic [FUNC_W-1:0] func;
    logic [BYTE_W-1:0] rx_data;

    modport source (output valid, func, rx_data, input ready);
    modport sink   (input valid, func, rx_data, output ready);
endinterface

interface atrlc_out_if;
    import atrlc_pkg::*;

    logic             valid;
    logic             ready;
    logic [1:0]       event_kind;
    logic [3:0]       line_class;
    logic [LEN_W-1:0] line_length;
    logic [1:0]       wait_status;
    logic             wait_done;

    modport source (output valid, event_kind, line_class, line_length, wait_status,
                    wait_done, input ready);
    modport sink   (input valid, event_kind, line_class, line_length, wait_status,
                    wait_done, output ready);
endinterface

interface atrlc_cfg_if;
    import atrlc_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [REG_IDX_W-1:0]  reg_index;
    logic [CFG_DATA_W-1:0] wr_data;

    modport source (output valid, reg_index, wr_data, input ready);
    modport sink   (input valid, reg_index, wr_data, output ready);
endinterface

// File: src/atrlc_front.sv
module atrlc_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    atrlc_in_if.sink            i_in,
    atrlc_cfg_if.sink           i_cfg,
    input  atrlc_pkg::t_q_stat  i_q_stat,
    output logic                o_push,
    output atrlc_pkg::t_result  o_push_data
);
    import atrlc_pkg::*;

    // true when the first n stored characters spell s (first char in the top byte)
    function automatic logic f_head_is(
        input logic [PREFIX_DEPTH-1:0][BYTE_W-1:0] pre,
        input logic [BYTE_W*PREFIX_DEPTH-1:0]      s,
        input int unsigned                         n
    );
        logic eq;
        eq = 1'b1;
        for (int unsigned i = 0; i < PREFIX_DEPTH; i++) begin
            if (i < n) begin
                if (pre[i] != s[BYTE_W*(n-1-i) +: BYTE_W]) begin
                    eq = 1'b0;
                end
            end
        end
        return eq;
    endfunction

    logic [MODE_W-1:0]                  r_wait_mode;
    logic [TICK_W-1:0]                  r_timeout_ticks;
    t_phase                             r_phase, n_phase;
    logic [TICK_W-1:0]                  r_elapsed, n_elapsed;
    logic [LEN_W-1:0]                   r_line_count, n_line_count;
    logic [PREFIX_DEPTH-1:0][BYTE_W-1:0] r_prefix;

    logic              accept;
    t_func             func;
    logic [BYTE_W-1:0] c;
    logic [TICK_W-1:0] tick_next;
    logic              tick_expire;
    t_class            cls;
    t_status           status;
    logic              prefix_we;
    logic              can_grow;

    assign i_in.ready = !i_q_stat.full;
    assign accept     = i_in.valid && !i_q_stat.full;
    assign func       = t_func'(i_in.func);
    assign c          = i_in.rx_data;

    // configuration registers, always ready
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wait_mode     <= MODE_W'(MODE_COLLECT);
            r_timeout_ticks <= TIMEOUT_RESET;
        end else if (i_cfg.valid) begin
            if (i_cfg.reg_index == REG_WAIT_MODE) begin
                r_wait_mode <= i_cfg.wr_data[MODE_W-1:0];
            end else if (i_cfg.reg_index == REG_TIMEOUT) begin
                r_timeout_ticks <= i_cfg.wr_data[TICK_W-1:0];
            end
        end
    end

    // saturating tick count and timeout compare
    assign tick_next   = (r_elapsed == TICK_MAX) ? r_elapsed : r_elapsed + 1'b1;
    assign tick_expire = (tick_next >= r_timeout_ticks);

    // line class from the stored prefix
    always_comb begin
        if (r_line_count == '0) begin
            cls = CL_BLANK;
        end else if (r_line_count == LEN_W'(2) && f_head_is(r_prefix, "OK", 2)) begin
            cls = CL_OK;
        end else if (r_line_count == LEN_W'(5) && f_head_is(r_prefix, "ERROR", 5)) begin
            cls = CL_ERROR;
        end else if (r_line_count == LEN_W'(4) && f_head_is(r_prefix, "FAIL", 4)) begin
            cls = CL_FAIL;
        end else if (r_line_count >= LEN_W'(4) && f_head_is(r_prefix, "busy", 4)) begin
            cls = CL_BUSY;
        end else if (r_line_count == LEN_W'(5) && f_head_is(r_prefix, "ready", 5)) begin
            cls = CL_READY;
        end else if (r_line_count == LEN_W'(7) && f_head_is(r_prefix, "SEND OK", 7)) begin
            cls = CL_SEND_OK;
        end else if (r_line_count == LEN_W'(9) && f_head_is(r_prefix, "SEND FAIL", 9)) begin
            cls = CL_SEND_FAIL;
        end else begin
            cls = CL_OTHER;
        end
    end

    // final status by mode, read live
    always_comb begin
        status = ST_WAIT;
        case (r_wait_mode)
            MODE_READY: begin
                if (cls == CL_READY) status = ST_SUCCESS;
            end
            MODE_SEND: begin
                if (cls == CL_SEND_OK || cls == CL_OK) status = ST_SUCCESS;
                else if (cls == CL_ERROR || cls == CL_SEND_FAIL) status = ST_ERROR;
            end
            default: begin
                if (cls == CL_OK) status = ST_SUCCESS;
                else if (cls == CL_ERROR || cls == CL_FAIL) status = ST_ERROR;
            end
        endcase
    end

    // phase next state
    always_comb begin
        n_phase = r_phase;
        if (accept) begin
            case (func)
                FUNC_START: begin
                    n_phase = (r_wait_mode == MODE_W'(MODE_SEND)) ? PH_PROMPT : PH_LINES;
                end
                FUNC_TICK: begin
                    if (r_phase != PH_IDLE && tick_expire) n_phase = PH_IDLE;
                end
                FUNC_BYTE: begin
                    case (r_phase)
                        PH_PROMPT: begin
                            if (c == CH_PROMPT) n_phase = PH_LINES;
                        end
                        PH_LINES: begin
                            if (c == CH_LF && status != ST_WAIT) n_phase = PH_IDLE;
                        end
                        default: n_phase = r_phase;
                    endcase
                end
                default: n_phase = r_phase;
            endcase
        end
    end

    // result generation
    always_comb begin
        o_push                  = 1'b0;
        o_push_data.event_kind  = EV_LINE;
        o_push_data.line_class  = CL_BLANK;
        o_push_data.line_length = '0;
        o_push_data.wait_status = ST_WAIT;
        if (accept && r_phase != PH_IDLE) begin
            case (func)
                FUNC_TICK: begin
                    if (tick_expire) begin
                        o_push                  = 1'b1;
                        o_push_data.event_kind  = EV_TIMEOUT;
                        o_push_data.wait_status = ST_TIMEOUT;
                    end
                end
                FUNC_BYTE: begin
                    if (r_phase == PH_PROMPT) begin
                        if (c == CH_PROMPT) begin
                            o_push                 = 1'b1;
                            o_push_data.event_kind = EV_PROMPT;
                        end
                    end else if (c == CH_LF) begin
                        o_push                  = 1'b1;
                        o_push_data.line_class  = cls;
                        o_push_data.line_length = r_line_count;
                        o_push_data.wait_status = status;
                    end
                end
                default: o_push = 1'b0;
            endcase
        end
    end

    // line assembly and tick counting
    assign can_grow  = (r_line_count < LEN_W'(LEN_CAP));
    assign prefix_we = accept && func == FUNC_BYTE && r_phase == PH_LINES
                       && c != CH_CR && c != CH_LF && can_grow
                       && r_line_count < LEN_W'(PREFIX_DEPTH);

    always_comb begin
        n_elapsed    = r_elapsed;
        n_line_count = r_line_count;
        if (accept) begin
            case (func)
                FUNC_START: begin
                    n_elapsed    = '0;
                    n_line_count = '0;
                end
                FUNC_TICK: begin
                    if (r_phase != PH_IDLE) n_elapsed = tick_next;
                end
                FUNC_BYTE: begin
                    if (r_phase == PH_PROMPT) begin
                        if (c == CH_PROMPT) n_line_count = '0;
                    end else if (r_phase == PH_LINES) begin
                        if (c == CH_LF) n_line_count = '0;
                        else if (c != CH_CR && can_grow) n_line_count = r_line_count + 1'b1;
                    end
                end
                default: n_elapsed = r_elapsed;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_elapsed    <= '0;
            r_line_count <= '0;
        end else begin
            r_phase      <= n_phase;
            r_elapsed    <= n_elapsed;
            r_line_count <= n_line_count;
        end
    end

    // prefix characters, no reset
    always_ff @(posedge i_clk) begin
        if (prefix_we) begin
            r_prefix[r_line_count[PREFIX_IDX_W-1:0]] <= c;
        end
    end

    a_final_goes_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push && o_push_data.wait_status != ST_WAIT) |=> (r_phase == PH_IDLE))
        else $error("final result did not end the wait");

    a_no_result_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> (r_phase != PH_IDLE))
        else $error("result produced while idle");

    a_len_capped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_line_count <= LEN_W'(LEN_CAP))
        else $error("line length past cap");

endmodule

// File: src/atrlc_fifo.sv
module atrlc_fifo (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  atrlc_pkg::t_result  i_push_data,
    input  logic                i_pop,
    output atrlc_pkg::t_result  o_pop_data,
    output atrlc_pkg::t_q_stat  o_stat
);
    import atrlc_pkg::*;

    t_result              r_mem [QUEUE_DEPTH];
    logic [Q_PTR_W-1:0]   r_wr_ptr, n_wr_ptr;
    logic [Q_PTR_W-1:0]   r_rd_ptr, n_rd_ptr;
    logic [Q_CNT_W-1:0]   r_count, n_count;

    assign o_stat.full  = (r_count == Q_CNT_W'(QUEUE_DEPTH));
    assign o_stat.empty = (r_count == '0);
    assign o_pop_data   = r_mem[r_rd_ptr];

    // pointer and fill count update
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == Q_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == Q_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) n_count = r_count + 1'b1;
        else if (!i_push && i_pop) n_count = r_count - 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // storage, no reset
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_stat.full)
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_stat.empty)
        else $error("pop from empty queue");

endmodule

// File: src/atrlc_back.sv
module atrlc_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  atrlc_pkg::t_q_stat  i_q_stat,
    input  atrlc_pkg::t_result  i_q_data,
    output logic                o_pop,
    atrlc_out_if.source         o_out
);
    import atrlc_pkg::*;

    logic    r_valid;
    t_result r_result;

    // refill the output register when it is empty or being taken
    assign o_pop = !i_q_stat.empty && (!r_valid || o_out.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_result <= i_q_data;
        end
    end

    // drive the result word
    assign o_out.valid       = r_valid;
    assign o_out.event_kind  = r_result.event_kind;
    assign o_out.line_class  = r_result.line_class;
    assign o_out.line_length = r_result.line_length;
    assign o_out.wait_status = r_result.wait_status;
    assign o_out.wait_done   = (r_result.wait_status != ST_WAIT);

endmodule

// File: src/at_response_line_classifier.sv
// channel  | modport | payload                                              | accepted when
// i_in     | sink    | func, rx_data                                        | valid && ready
// i_cfg    | sink    | reg_index, wr_data                                   | valid && ready
// o_out    | source  | event_kind, line_class, line_length, wait_status,    | valid && ready
//          |         | wait_done                                            |
//
// one input word per cycle unless the queue is full; each word is decoded and classified
// in the cycle it is taken, then its result passes through the queue and the output register
// a four-entry queue and the output register decouple the two sides
// i_in.ready drops only while the queue is full; i_cfg is always ready
// synchronous active-low reset returns to idle with wait_mode 0, timeout 1000
module at_response_line_classifier (
    input  logic         i_clk,
    input  logic         i_rst_n,
    atrlc_in_if.sink     i_in,
    atrlc_cfg_if.sink    i_cfg,
    atrlc_out_if.source  o_out
);
    import atrlc_pkg::*;

    t_q_stat q_stat;
    t_result push_data;
    t_result pop_data;
    logic    push;
    logic    pop;

    // decode, line assembly and wait control
    atrlc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_cfg       (i_cfg),
        .i_q_stat    (q_stat),
        .o_push      (push),
        .o_push_data (push_data)
    );

    // result queue
    atrlc_fifo u_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (push_data),
        .i_pop       (pop),
        .o_pop_data  (pop_data),
        .o_stat      (q_stat)
    );

    // output register
    atrlc_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_q_stat (q_stat),
        .i_q_data (pop_data),
        .o_pop    (pop),
        .o_out    (o_out)
    );

endmodule

// File: test/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import atrlc_pkg::*;

    localparam int CYCLE_LIMIT = 400_000;
    localparam int PHASE_WORDS = 55;
    localparam int DRAIN_CYCLES = 8;

    // mode code outside the named ones, handled like collect mode
    localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

    // predicts the result words of the line classifier and checks them in order
    class line_scoreboard;
        typedef struct packed {
            t_event           kind;
            t_class           cls;
            logic [LEN_W-1:0] len;
            t_status          status;
            logic             done;
        } t_verdict;

        t_verdict          expected_q[$];
        logic [MODE_W-1:0] wait_mode;
        logic [TICK_W-1:0] timeout_ticks;
        t_phase            phase;
        logic [TICK_W-1:0] elapsed;
        logic [LEN_W-1:0]  line_len;
        logic [7:0]        prefix[PREFIX_DEPTH];
        int                errors;

        function new();
            wait_mode     = MODE_COLLECT;
            timeout_ticks = TIMEOUT_RESET;
            phase         = PH_IDLE;
            elapsed       = '0;
            line_len      = '0;
            errors        = 0;
            foreach (prefix[i]) prefix[i] = 8'h00;
        endfunction

        function void write_reg(logic [REG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_WAIT_MODE: wait_mode = data[MODE_W-1:0];
                REG_TIMEOUT:   timeout_ticks = data[TICK_W-1:0];
                default: ;
            endcase
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void expect_word(t_event k, t_class c, logic [LEN_W-1:0] n, t_status s,
                                  logic d);
            t_verdict v;
            v.kind   = k;
            v.cls    = c;
            v.len    = n;
            v.status = s;
            v.done   = d;
            expected_q.push_back(v);
        endfunction

        // first n stored characters equal the text
        function bit prefix_is(string s, int n);
            for (int i = 0; i < n; i++) begin
                if (prefix[i] != s[i]) return 1'b0;
            end
            return 1'b1;
        endfunction

        function bit line_equals(string s);
            return (line_len == s.len()) && (s.len() <= PREFIX_DEPTH) && prefix_is(s, s.len());
        endfunction

        function t_class classify_line();
            if (line_len == 0) return CL_BLANK;
            if (line_equals("OK")) return CL_OK;
            if (line_equals("ERROR")) return CL_ERROR;
            if (line_equals("FAIL")) return CL_FAIL;
            if (line_len >= 4 && prefix_is("busy", 4)) return CL_BUSY;
            if (line_equals("ready")) return CL_READY;
            if (line_equals("SEND OK")) return CL_SEND_OK;
            if (line_equals("SEND FAIL")) return CL_SEND_FAIL;
            return CL_OTHER;
        endfunction

        // returns 1 when the word was not simply ignored
        function bit note_word(logic [FUNC_W-1:0] f, logic [7:0] c);
            t_class  cls;
            t_status st;
            if (f == FUNC_START) begin
                phase    = (wait_mode == MODE_SEND) ? PH_PROMPT : PH_LINES;
                elapsed  = '0;
                line_len = '0;
                return 1'b1;
            end
            if (f == FUNC_NONE || phase == PH_IDLE) return 1'b0;

            // tick: saturating count, timeout ends the wait
            if (f == FUNC_TICK) begin
                if (elapsed != TICK_MAX) elapsed++;
                if (elapsed >= timeout_ticks) begin
                    phase = PH_IDLE;
                    expect_word(EV_TIMEOUT, CL_BLANK, '0, ST_TIMEOUT, 1'b1);
                end
                return 1'b1;
            end

            // waiting for the send prompt, everything else is dropped
            if (phase == PH_PROMPT) begin
                if (c == CH_PROMPT) begin
                    phase    = PH_LINES;
                    line_len = '0;
                    expect_word(EV_PROMPT, CL_BLANK, '0, ST_WAIT, 1'b0);
                end
                return 1'b1;
            end
            if (c == CH_CR) return 1'b1;

            // end of line: classify and apply the mode
            if (c == CH_LF) begin
                cls = classify_line();
                st  = ST_WAIT;
                case (wait_mode)
                    MODE_READY: begin
                        if (cls == CL_READY) st = ST_SUCCESS;
                    end
                    MODE_SEND: begin
                        if (cls == CL_SEND_OK || cls == CL_OK) st = ST_SUCCESS;
                        else if (cls == CL_ERROR || cls == CL_SEND_FAIL) st = ST_ERROR;
                    end
                    default: begin
                        if (cls == CL_OK) st = ST_SUCCESS;
                        else if (cls == CL_ERROR || cls == CL_FAIL) st = ST_ERROR;
                    end
                endcase
                expect_word(EV_LINE, cls, line_len, st, st != ST_WAIT);
                line_len = '0;
                if (st != ST_WAIT) phase = PH_IDLE;
                return 1'b1;
            end

            // ordinary character, clipped at the length cap
            if (line_len < LEN_CAP) begin
                if (line_len < PREFIX_DEPTH) prefix[line_len] = c;
                line_len++;
            end
            return 1'b1;
        endfunction

        function void check_word(logic [1:0] kind, logic [3:0] cls, logic [LEN_W-1:0] len,
                                 logic [1:0] status, logic done);
            t_verdict v;
            if (expected_q.size() == 0) begin
                $error("result word with nothing expected: kind %0d class %0d length %0d",
                       kind, cls, len);
                errors++;
                return;
            end
            v = expected_q.pop_front();
            if (v.kind !== kind) begin
                $error("event_kind mismatch: expected %0d, actual %0d", v.kind, kind);
                errors++;
            end
            if (v.cls !== cls) begin
                $error("line_class mismatch: expected %0d, actual %0d", v.cls, cls);
                errors++;
            end
            if (v.len !== len) begin
                $error("line_length mismatch: expected %0d, actual %0d", v.len, len);
                errors++;
            end
            if (v.status !== status) begin
                $error("wait_status mismatch: expected %0d, actual %0d", v.status, status);
                errors++;
            end
            if (v.done !== done) begin
                $error("wait_done mismatch: expected %0d, actual %0d", v.done, done);
                errors++;
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    atrlc_in_if  in_if ();
    atrlc_cfg_if cfg_if ();
    atrlc_out_if out_if ();

    at_response_line_classifier u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .i_cfg   (cfg_if),
        .o_out   (out_if)
    );

    line_scoreboard sb;
    int             send_idle_pct;
    int             recv_stall_pct;
    int             sent_words;
    int             cycle_count;
    logic [7:0]     line_buf[$];

    // 10 ns clock
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("at_response_line_classifier test failed");
            $finish;
        end
    end

    // result side: check accepted words, stall at random
    initial begin
        out_if.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && out_if.valid && out_if.ready) begin
                sb.check_word(out_if.event_kind, out_if.line_class, out_if.line_length,
                              out_if.wait_status, out_if.wait_done);
            end
            out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // offer one input word, valid stays high after it is taken
    task automatic push_word(logic [FUNC_W-1:0] f, logic [7:0] d);
        while ($urandom_range(99) < send_idle_pct) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_if.valid   <= 1'b1;
        in_if.func    <= f;
        in_if.rx_data <= d;
        do @(posedge i_clk); while (!in_if.ready);
        void'(sb.note_word(f, d));
        sent_words++;
    endtask

    // stop input and let every expected word come out
    task automatic drain();
        in_if.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // both registers back to back, only while the block is quiet
    task automatic write_config(logic [MODE_W-1:0] mode, logic [TICK_W-1:0] ticks);
        cfg_if.valid     <= 1'b1;
        cfg_if.reg_index <= REG_WAIT_MODE;
        cfg_if.wr_data   <= CFG_DATA_W'(mode);
        do @(posedge i_clk); while (!cfg_if.ready);
        sb.write_reg(REG_WAIT_MODE, CFG_DATA_W'(mode));
        cfg_if.reg_index <= REG_TIMEOUT;
        cfg_if.wr_data   <= ticks;
        do @(posedge i_clk); while (!cfg_if.ready);
        sb.write_reg(REG_TIMEOUT, ticks);
        cfg_if.valid <= 1'b0;
    endtask

    function automatic void add_text(string s);
        for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
    endfunction

    function automatic logic [7:0] any_char();
        logic [7:0] c;
        c = 8'($urandom_range(255));
        return (c == CH_LF) ? 8'h7A : c;
    endfunction

    function automatic string keyword(int k);
        case (k)
            0: return "OK";
            1: return "ERROR";
            2: return "FAIL";
            3: return "busy";
            4: return "ready";
            5: return "SEND OK";
            default: return "SEND FAIL";
        endcase
    endfunction

    // pick a reply line, mostly known keywords
    function automatic void build_line();
        int r;
        int n;
        r = $urandom_range(99);
        line_buf.delete();
        if (r < 8) begin
        end else if (r < 22) begin
            add_text("OK");
        end else if (r < 30) begin
            add_text("ERROR");
        end else if (r < 36) begin
            add_text("FAIL");
        end else if (r < 44) begin
            add_text("busy");
            repeat ($urandom_range(8)) line_buf.push_back(8'($urandom_range(32, 126)));
        end else if (r < 52) begin
            add_text("ready");
        end else if (r < 60) begin
            add_text("SEND OK");
        end else if (r < 66) begin
            add_text("SEND FAIL");
        end else if (r < 80) begin
            // near miss of a keyword
            add_text(keyword($urandom_range(6)));
            case ($urandom_range(2))
                0: line_buf[$urandom_range(line_buf.size() - 1)] = any_char();
                1: line_buf.push_back(any_char());
                default: void'(line_buf.pop_back());
            endcase
        end else if (r < 97) begin
            repeat ($urandom_range(1, 12)) line_buf.push_back(any_char());
        end else begin
            // long line around the length cap
            n = $urandom_range(LEN_CAP - 2, LEN_CAP + 12);
            repeat (n) line_buf.push_back(8'($urandom_range(32, 126)));
        end
    endfunction

    // one line with stray carriage returns and ticks mixed in
    task automatic send_line();
        build_line();
        foreach (line_buf[i]) begin
            if ($urandom_range(99) < 4) push_word(FUNC_TICK, 8'($urandom_range(255)));
            if ($urandom_range(99) < 3) push_word(FUNC_BYTE, CH_CR);
            push_word(FUNC_BYTE, line_buf[i]);
        end
        if ($urandom_range(1)) push_word(FUNC_BYTE, CH_CR);
        push_word(FUNC_BYTE, CH_LF);
    endtask

    // a start followed by a reply, or a burst of noise
    task automatic run_exchange();
        if ($urandom_range(99) < 10) begin
            repeat ($urandom_range(1, 6))
                push_word(FUNC_W'($urandom_range(3)), 8'($urandom_range(255)));
        end else begin
            push_word(FUNC_START, 8'($urandom_range(255)));
            if (sb.wait_mode == MODE_SEND) begin
                repeat ($urandom_range(3)) push_word(FUNC_BYTE, 8'($urandom_range(255)));
                if ($urandom_range(9) != 0) push_word(FUNC_BYTE, CH_PROMPT);
            end
            repeat ($urandom_range(1, 5)) send_line();
        end
    endtask

    initial begin
        logic [MODE_W-1:0] mode;
        logic [TICK_W-1:0] ticks;

        sb               = new();
        cycle_count      = 0;
        sent_words       = 0;
        send_idle_pct    = 0;
        recv_stall_pct   = 0;
        i_rst_n          = 1'b0;
        in_if.valid      = 1'b0;
        in_if.func       = FUNC_BYTE;
        in_if.rx_data    = 8'h00;
        cfg_if.valid     = 1'b0;
        cfg_if.reg_index = REG_WAIT_MODE;
        cfg_if.wr_data   = '0;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // idle block ignores bytes, ticks and the unused code
        push_word(FUNC_BYTE, 8'h78);
        push_word(FUNC_TICK, 8'hFF);
        push_word(FUNC_NONE, 8'h00);
        // blank line, then OK ends the collect wait
        push_word(FUNC_START, 8'h00);
        push_word(FUNC_BYTE, CH_CR);
        push_word(FUNC_BYTE, CH_LF);
        push_word(FUNC_BYTE, 8'h4F);
        push_word(FUNC_BYTE, 8'h4B);
        push_word(FUNC_BYTE, CH_CR);
        push_word(FUNC_BYTE, CH_LF);
        // FAIL gives error
        push_word(FUNC_START, 8'hFF);
        push_word(FUNC_BYTE, 8'h46);
        push_word(FUNC_BYTE, 8'h41);
        push_word(FUNC_BYTE, 8'h49);
        push_word(FUNC_BYTE, 8'h4C);
        push_word(FUNC_BYTE, CH_LF);
        // extreme byte values make an other line, tick far from timeout
        push_word(FUNC_START, 8'h00);
        push_word(FUNC_TICK, 8'h00);
        push_word(FUNC_BYTE, 8'h00);
        push_word(FUNC_BYTE, 8'hFF);
        push_word(FUNC_BYTE, CH_LF);
        drain();
        // zero timeout: first tick ends the wait
        write_config(MODE_COLLECT, '0);
        push_word(FUNC_START, 8'h00);
        push_word(FUNC_TICK, 8'h00);
        drain();

        // random phases over modes, timeouts and idling
        for (int ph = 0; ph < 8; ph++) begin
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 67; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 67; end
                default: begin send_idle_pct = 11; recv_stall_pct = 11; end
            endcase
            case (ph)
                0: begin mode = MODE_COLLECT; ticks = TICK_MAX; end
                1: begin mode = MODE_READY;   ticks = 16'd20;   end
                2: begin mode = MODE_SEND;    ticks = 16'd8;    end
                3: begin mode = MODE_SPARE;   ticks = 16'd30;   end
                4: begin mode = MODE_SEND;    ticks = 16'd1;    end
                5: begin mode = MODE_COLLECT; ticks = '0;       end
                6: begin mode = MODE_READY;   ticks = 16'd200;  end
                default: begin mode = MODE_SEND; ticks = 16'd12; end
            endcase
            write_config(mode, ticks);
            sent_words = 0;
            while (sent_words < PHASE_WORDS) run_exchange();
            drain();
        end

        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("at_response_line_classifier test passed");
        end else begin
            $display("at_response_line_classifier test failed");
        end
        $finish;
    end

endmodule

// File: files.f
src/atrlc_pkg.sv
src/atrlc_if.sv
src/atrlc_front.sv
src/atrlc_fifo.sv
src/atrlc_back.sv
src/at_response_line_classifier.sv
test/testbench.sv
